// ===== sv/feg_pkg.sv =====
package feg_pkg;

    localparam int PIXEL_INDEX_W = 15;
    localparam int HEAT_W        = 8;
    localparam int COLOR_W       = 32;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;
    localparam int ROWS_W        = 7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPARK_ROWS     = 2'd0,
        CFG_DARK_ROWS      = 2'd1,
        CFG_DARK_THRESHOLD = 2'd2,
        CFG_DARK_BASE      = 2'd3
    } t_cfg_index;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_READ  = 1'b1
    } t_opcode;

    localparam logic [ROWS_W-1:0] SPARK_ROWS_RST     = 7'd4;
    localparam logic [ROWS_W-1:0] DARK_ROWS_RST      = 7'd7;
    localparam logic [HEAT_W-1:0] DARK_THRESHOLD_RST = 8'd15;
    localparam logic [HEAT_W-1:0] DARK_BASE_RST      = 8'd22;

    typedef struct packed {
        logic                     opcode;
        logic [PIXEL_INDEX_W-1:0] pixel_index;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [HEAT_W-1:0]  heat;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic frame_start;
        logic frame_step;
        logic read_issue;
        logic read_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic frame_last;
        logic pipe_empty;
    } t_dp_sts;

    // red, green, blue of the low palette entries; above these lies white heat
    localparam logic [17:0] LOW_RGB [64] = '{
        {6'd0, 6'd0, 6'd0},   {6'd0, 6'd1, 6'd1},   {6'd0, 6'd4, 6'd5},   {6'd0, 6'd7, 6'd9},
        {6'd0, 6'd8, 6'd11},  {6'd0, 6'd9, 6'd12},  {6'd15, 6'd6, 6'd8},  {6'd25, 6'd4, 6'd4},
        {6'd33, 6'd3, 6'd3},  {6'd40, 6'd2, 6'd2},  {6'd48, 6'd2, 6'd2},  {6'd55, 6'd1, 6'd1},
        {6'd63, 6'd0, 6'd0},  {6'd63, 6'd0, 6'd0},  {6'd63, 6'd3, 6'd0},  {6'd63, 6'd7, 6'd0},
        {6'd63, 6'd10, 6'd0}, {6'd63, 6'd13, 6'd0}, {6'd63, 6'd16, 6'd0}, {6'd63, 6'd20, 6'd0},
        {6'd63, 6'd23, 6'd0}, {6'd63, 6'd26, 6'd0}, {6'd63, 6'd29, 6'd0}, {6'd63, 6'd33, 6'd0},
        {6'd63, 6'd36, 6'd0}, {6'd63, 6'd39, 6'd0}, {6'd63, 6'd39, 6'd0}, {6'd63, 6'd40, 6'd0},
        {6'd63, 6'd40, 6'd0}, {6'd63, 6'd41, 6'd0}, {6'd63, 6'd42, 6'd0}, {6'd63, 6'd42, 6'd0},
        {6'd63, 6'd43, 6'd0}, {6'd63, 6'd44, 6'd0}, {6'd63, 6'd44, 6'd0}, {6'd63, 6'd45, 6'd0},
        {6'd63, 6'd45, 6'd0}, {6'd63, 6'd46, 6'd0}, {6'd63, 6'd47, 6'd0}, {6'd63, 6'd47, 6'd0},
        {6'd63, 6'd48, 6'd0}, {6'd63, 6'd49, 6'd0}, {6'd63, 6'd49, 6'd0}, {6'd63, 6'd50, 6'd0},
        {6'd63, 6'd51, 6'd0}, {6'd63, 6'd51, 6'd0}, {6'd63, 6'd52, 6'd0}, {6'd63, 6'd53, 6'd0},
        {6'd63, 6'd53, 6'd0}, {6'd63, 6'd54, 6'd0}, {6'd63, 6'd55, 6'd0}, {6'd63, 6'd55, 6'd0},
        {6'd63, 6'd56, 6'd0}, {6'd63, 6'd57, 6'd0}, {6'd63, 6'd57, 6'd0}, {6'd63, 6'd58, 6'd0},
        {6'd63, 6'd58, 6'd0}, {6'd63, 6'd59, 6'd0}, {6'd63, 6'd60, 6'd0}, {6'd63, 6'd60, 6'd0},
        {6'd63, 6'd61, 6'd0}, {6'd63, 6'd62, 6'd0}, {6'd63, 6'd62, 6'd0}, {6'd63, 6'd63, 6'd0}
    };

    localparam logic [5:0] WHITE_LEVEL = 6'd62;

    function automatic logic [COLOR_W-1:0] palette_of(input logic [HEAT_W-1:0] heat);
        logic [5:0] r;
        logic [5:0] g;
        logic [5:0] b;
        logic [7:0] total;
        if (heat[7:6] != 2'b00) begin
            r = WHITE_LEVEL;
            g = WHITE_LEVEL;
            b = WHITE_LEVEL;
        end else begin
            {r, g, b} = LOW_RGB[heat[5:0]];
        end
        total = {2'b00, r} + {2'b00, g} + {2'b00, b};
        return {total, r, 2'b00, g, 2'b00, b, 2'b00};
    endfunction

endpackage

// ===== sv/feg_stream_if.sv =====
interface feg_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/feg_ram.sv =====
module feg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 19200
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/feg_ctrl.sv =====
module feg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_opcode,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  feg_pkg::t_dp_sts  i_sts,
    output feg_pkg::t_dp_cmd  o_cmd
);
    import feg_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_FRAME = 5'b00100,
        S_FLUSH = 5'b01000,
        S_READ  = 5'b10000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (t_opcode'(i_opcode) == OP_FRAME) begin
                        cmd.frame_start = 1'b1;
                        n_state         = S_FRAME;
                    end else begin
                        cmd.read_issue = 1'b1;
                        n_state        = S_READ;
                    end
                end
            end
            S_FRAME: begin
                cmd.frame_step = 1'b1;
                if (i_sts.frame_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                // hold the fetched heat until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    cmd.read_load = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (cmd.read_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// ===== sv/feg_datapath.sv =====
module feg_datapath #(
    parameter int MAP_WIDTH  = 160,
    parameter int MAP_HEIGHT = 120
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  feg_pkg::t_dp_cmd                    i_cmd,
    output feg_pkg::t_dp_sts                    o_sts,
    input  logic [feg_pkg::PIXEL_INDEX_W-1:0]   i_pixel_index,
    input  logic                                i_cfg_we,
    input  logic [feg_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [feg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [feg_pkg::COLOR_W-1:0]         o_color,
    output logic [feg_pkg::HEAT_W-1:0]          o_heat
);
    import feg_pkg::*;

    localparam int CELLS    = MAP_WIDTH * MAP_HEIGHT;
    localparam int LAST_I   = (MAP_HEIGHT - 1) * MAP_WIDTH - 1;
    localparam int SHOWN    = (MAP_HEIGHT - 2) * MAP_WIDTH;
    localparam int CELL_AW  = $clog2(CELLS);
    localparam int CNT_W    = $clog2(CELLS + 1);
    localparam int COL_W    = $clog2(MAP_WIDTH);
    localparam int ROW_W    = $clog2(MAP_HEIGHT);
    localparam int ROWCMP_W = $clog2(MAP_HEIGHT + 128) + 1;
    localparam int PIX_SW   = ((CELL_AW > PIXEL_INDEX_W) ? CELL_AW : PIXEL_INDEX_W) + 1;
    localparam int WIN_LEN  = 2 * MAP_WIDTH + 2;

    // configuration
    logic [ROWS_W-1:0] r_spark_rows;
    logic [ROWS_W-1:0] r_dark_rows;
    logic [HEAT_W-1:0] r_dark_thr;
    logic [HEAT_W-1:0] r_dark_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spark_rows <= SPARK_ROWS_RST;
            r_dark_rows  <= DARK_ROWS_RST;
            r_dark_thr   <= DARK_THRESHOLD_RST;
            r_dark_base  <= DARK_BASE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SPARK_ROWS:     r_spark_rows <= i_cfg_data[ROWS_W-1:0];
                CFG_DARK_ROWS:      r_dark_rows  <= i_cfg_data[ROWS_W-1:0];
                CFG_DARK_THRESHOLD: r_dark_thr   <= i_cfg_data;
                CFG_DARK_BASE:      r_dark_base  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clearing sweep after reset
    logic [CELL_AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // frame pass, issue stage: previous map read leads the cell by one row and one cell
    logic [CNT_W-1:0]   r_rd_cnt;
    logic               r_i_on;
    logic [CELL_AW-1:0] r_i_addr;
    logic [COL_W-1:0]   r_i_col;
    logic [ROW_W-1:0]   r_i_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.frame_start) begin
            r_rd_cnt <= '0;
            r_i_on   <= 1'b0;
            r_i_addr <= '0;
            r_i_col  <= '0;
            r_i_row  <= '0;
        end else if (i_cmd.frame_step) begin
            r_rd_cnt <= r_rd_cnt + 1'b1;
            if (!r_i_on) begin
                if (r_rd_cnt == CNT_W'(MAP_WIDTH)) begin
                    r_i_on <= 1'b1;
                end
            end else begin
                r_i_addr <= r_i_addr + 1'b1;
                if (r_i_col == COL_W'(MAP_WIDTH - 1)) begin
                    r_i_col <= '0;
                    r_i_row <= r_i_row + 1'b1;
                end else begin
                    r_i_col <= r_i_col + 1'b1;
                end
            end
        end
    end

    // stage B: RAM data arrives
    logic               r_b_go;
    logic               r_b_i_on;
    logic [CELL_AW-1:0] r_b_i_addr;
    logic [COL_W-1:0]   r_b_col;
    logic [ROW_W-1:0]   r_b_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_go   <= 1'b0;
            r_b_i_on <= 1'b0;
        end else begin
            r_b_go   <= i_cmd.frame_step;
            r_b_i_on <= i_cmd.frame_step && r_i_on;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_i_addr <= r_i_addr;
        r_b_col    <= r_i_col;
        r_b_row    <= r_i_row;
    end

    // memories
    logic               cur_we;
    logic [CELL_AW-1:0] cur_waddr;
    logic [HEAT_W-1:0]  cur_wdata;
    logic               cur_re;
    logic [CELL_AW-1:0] cur_raddr;
    logic [HEAT_W-1:0]  cur_rdata;
    logic               prev_we;
    logic [CELL_AW-1:0] prev_waddr;
    logic [HEAT_W-1:0]  prev_wdata;
    logic [CELL_AW-1:0] prev_raddr;
    logic [HEAT_W-1:0]  prev_rdata;

    feg_ram #(.WIDTH(HEAT_W), .DEPTH(CELLS)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_re    (cur_re),
        .i_raddr (cur_raddr),
        .o_rdata (cur_rdata)
    );

    feg_ram #(.WIDTH(HEAT_W), .DEPTH(CELLS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (i_cmd.frame_step),
        .i_raddr (prev_raddr),
        .o_rdata (prev_rdata)
    );

    // neighbour window over the previous map, newest sample at the RAM output
    logic [HEAT_W-1:0] r_win [WIN_LEN];

    always_ff @(posedge i_clk) begin
        if (r_b_go) begin
            r_win[0] <= prev_rdata;
            for (int k = 1; k < WIN_LEN; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    logic [HEAT_W+2:0]   sum;
    logic [HEAT_W-1:0]   avg;
    logic                spark;
    logic                dark;
    logic                update;
    logic                cool;
    logic [HEAT_W-1:0]   heat_upd;
    logic [HEAT_W-1:0]   heat_dark;

    always_comb begin
        sum = (HEAT_W+3)'(prev_rdata)
            + (HEAT_W+3)'(r_win[0])
            + (HEAT_W+3)'(r_win[1])
            + (HEAT_W+3)'(r_win[MAP_WIDTH-1])
            + (HEAT_W+3)'(r_win[MAP_WIDTH+1])
            + (HEAT_W+3)'(r_win[2*MAP_WIDTH-1])
            + (HEAT_W+3)'(r_win[2*MAP_WIDTH])
            + (HEAT_W+3)'(r_win[2*MAP_WIDTH+1]);
        avg    = sum[HEAT_W+2:3];
        spark  = (ROWCMP_W'(r_b_row) + ROWCMP_W'(r_spark_rows)) >= ROWCMP_W'(MAP_HEIGHT);
        dark   = (ROWCMP_W'(r_b_row) + ROWCMP_W'(r_dark_rows)) >= ROWCMP_W'(MAP_HEIGHT);
        // the top row, the first cell of the second row and the last cell before the bottom row stay put
        update = (r_b_row != '0)
              && !(r_b_row == ROW_W'(1) && r_b_col == '0)
              && !(r_b_row == ROW_W'(MAP_HEIGHT - 2) && r_b_col == COL_W'(MAP_WIDTH - 1));
        cool   = (sum[1:0] == 2'b00) && ((avg != '0) || spark);
        heat_upd  = update ? (avg - HEAT_W'(cool)) : cur_rdata;
        heat_dark = (dark && (heat_upd < r_dark_thr)) ? (r_dark_base - heat_upd) : heat_upd;
    end

    // stage C: write back
    logic               r_w_cur_we;
    logic               r_w_prev_we;
    logic [CELL_AW-1:0] r_w_cur_addr;
    logic [CELL_AW-1:0] r_w_prev_addr;
    logic [HEAT_W-1:0]  r_w_cur_data;
    logic [HEAT_W-1:0]  r_w_prev_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_cur_we  <= 1'b0;
            r_w_prev_we <= 1'b0;
        end else begin
            r_w_cur_we  <= r_b_i_on;
            r_w_prev_we <= r_b_i_on && (r_b_row != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_cur_addr  <= r_b_i_addr;
        r_w_prev_addr <= r_b_i_addr - CELL_AW'(MAP_WIDTH);
        r_w_cur_data  <= heat_dark;
        r_w_prev_data <= heat_upd;
    end

    // pixel read
    logic [PIX_SW-1:0] pix_ext;
    logic [PIX_SW-1:0] pix_cell;
    logic              r_rd_oob;

    assign pix_ext  = PIX_SW'(i_pixel_index);
    assign pix_cell = pix_ext + PIX_SW'(MAP_WIDTH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_issue) begin
            r_rd_oob <= (pix_ext >= PIX_SW'(SHOWN));
        end
    end

    // port muxes
    always_comb begin
        if (i_cmd.clear_step) begin
            cur_we     = 1'b1;
            cur_waddr  = r_clr_addr;
            cur_wdata  = '0;
            prev_we    = 1'b1;
            prev_waddr = r_clr_addr;
            prev_wdata = '0;
        end else begin
            cur_we     = r_w_cur_we;
            cur_waddr  = r_w_cur_addr;
            cur_wdata  = r_w_cur_data;
            prev_we    = r_w_prev_we;
            prev_waddr = r_w_prev_addr;
            prev_wdata = r_w_prev_data;
        end
        cur_re     = i_cmd.read_issue || (i_cmd.frame_step && r_i_on);
        cur_raddr  = i_cmd.read_issue ? pix_cell[CELL_AW-1:0] : r_i_addr;
        prev_raddr = (r_rd_cnt == CNT_W'(CELLS)) ? '0 : r_rd_cnt[CELL_AW-1:0];
    end

    // output register
    logic [COLOR_W-1:0] r_color;
    logic [HEAT_W-1:0]  r_heat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_load) begin
            r_color <= r_rd_oob ? '0 : palette_of(cur_rdata);
            r_heat  <= r_rd_oob ? '0 : cur_rdata;
        end
    end

    assign o_color = r_color;
    assign o_heat  = r_heat;

    assign o_sts.clear_last = (r_clr_addr == CELL_AW'(CELLS - 1));
    assign o_sts.frame_last = r_i_on && (r_i_addr == CELL_AW'(LAST_I));
    assign o_sts.pipe_empty = !r_b_go && !r_w_cur_we && !r_w_prev_we;
endmodule

// ===== sv/fire_effect_generator.sv =====
// Fire effect generator: two byte heat maps of MAP_WIDTH x MAP_HEIGHT cells with a
// 256-entry palette.
// Input channel i_in carries an opcode and a pixel index. An advance request walks
// the whole map once and returns nothing; a read request returns one palette colour
// and heat on o_out, or zeros when the index lies past the displayed area.
// Configuration registers (spark rows, dark rows, dark threshold, dark base) are
// written through i_cfg_we / i_cfg_index / i_cfg_data. The user must write them
// only while the block is idle; the block itself does not enforce this. A read's
// heat is fetched from the map memory, then loaded into the output register once it
// is free. An advance handles one cell per cycle through the read and write ports of
// each map memory, with the previous-map read running one row and one cell ahead.
// Reset: a clearing pass writes zero to all MAP_WIDTH*MAP_HEIGHT cells of both maps,
// one cell per cycle; no request is taken meanwhile. Configuration returns to its
// defaults at once.
// Stall: the output register holds a result until o_out.ready; advance requests
// are still taken meanwhile, and a further read waits for the register to free.
module fire_effect_generator #(
    parameter int MAP_WIDTH  = 160,
    parameter int MAP_HEIGHT = 120
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    feg_stream_if.sink                        i_in,
    feg_stream_if.source                      o_out,
    input  logic                              i_cfg_we,
    input  logic [feg_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [feg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import feg_pkg::*;

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic [COLOR_W-1:0] color;
    logic [HEAT_W-1:0]  heat;
    t_in_item           in_item;

    assign in_item = i_in.payload;

    feg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_opcode    (in_item.opcode),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    feg_datapath #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_pixel_index (in_item.pixel_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_color       (color),
        .o_heat        (heat)
    );

    assign o_out.payload = '{color: color, heat: heat};
endmodule
